>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the selective repeat receiver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("srr assertion failed");

// The expression must hold in every cycle out of reset.
`define SRR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("srr assertion failed");

`endif

>>> rtl/core/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types, sizes and helper functions of the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int BUFFER_SLOTS = 16;
	localparam int SEQ_SPACE    = 256;
	localparam int SEQ_W        = 8;
	localparam int SLOT_W       = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SEQ_W-1:0]  seq_t;
	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		CMD_DELIVER,
		CMD_DUP,
		CMD_STORE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		seq_t      seq;
		logic      intact;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} back_state_t;

	// Receive state the front needs to classify an arrival.
	typedef struct packed {
		seq_t last_delivered;
		logic any_delivered;
		logic idle;
		logic scanning;
	} back_status_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	// Slot that a sequence number maps to, as a constant lookup.
	typedef slot_idx_t slot_map_t [2**SEQ_W];

	function automatic slot_map_t build_slot_map();
		slot_map_t m;
		for (int i = 0; i < 2**SEQ_W; i++) begin
			m[i] = SLOT_W'(i % BUFFER_SLOTS);
		end
		return m;
	endfunction

	localparam slot_map_t SLOT_MAP = build_slot_map();

	// Successor of a delivered number within the sequence space.
	function automatic seq_t next_seq(input seq_t v);
		logic [SEQ_W:0] sum;
		sum = {1'b0, v} + (SEQ_W+1)'(1);
		if (int'(sum) >= SEQ_SPACE) begin
			return SEQ_W'(int'(sum) - SEQ_SPACE);
		end
		return sum[SEQ_W-1:0];
	endfunction

	function automatic seq_t expected_seq(input logic any, input seq_t last);
		return any ? next_seq(last) : '0;
	endfunction

endpackage

>>> rtl/core/srr_queue.sv
// ----------------------------------------------------------------------------
// srr_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module srr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  srr_pkg::cmd_t          push_cmd,
	input  logic                   pop,
	output logic                   head_valid,
	output srr_pkg::cmd_t          head_cmd,
	output srr_pkg::queue_status_t status
);
	import srr_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign do_push = push && (count_q != QCNT_W'(QUEUE_DEPTH));
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head_valid   = (count_q != '0);
	assign head_cmd     = entry_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

endmodule

>>> rtl/core/srr_front.sv
// ----------------------------------------------------------------------------
// srr_front
// Accepts arriving packets and sorts them into deliver, duplicate or store.
// ----------------------------------------------------------------------------
module srr_front (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             seq_num,
	input  logic                   intact,
	input  srr_pkg::back_status_t  back_status,
	input  srr_pkg::queue_status_t q_status,
	output logic                   push,
	output srr_pkg::cmd_t          push_cmd
);
	import srr_pkg::*;

	seq_t expected;
	logic accept;
	logic in_order;
	logic is_old;

	// Classification reads the receive state, so an item waits until all
	// earlier work has left both the queue and the back end.
	assign in_stall = !(back_status.idle && q_status.empty);
	assign accept   = in_valid && !in_stall;

	assign expected = expected_seq(back_status.any_delivered, back_status.last_delivered);
	assign in_order = (seq_num == expected);
	assign is_old   = back_status.any_delivered && (seq_num <= back_status.last_delivered);

	always_comb begin
		push_cmd.seq    = seq_num;
		push_cmd.intact = intact;
		if (in_order) begin
			push_cmd.kind = CMD_DELIVER;
		end else if (is_old) begin
			push_cmd.kind = CMD_DUP;
		end else begin
			push_cmd.kind = CMD_STORE;
		end
	end

	// An in-order packet that arrived corrupt is simply dropped.
	assign push = accept && !(in_order && !intact);

endmodule

>>> rtl/core/srr_back.sv
// ----------------------------------------------------------------------------
// srr_back
// Executes queued commands: parks packets, scans the reorder slots and
// drives the acknowledgement output register.
// ----------------------------------------------------------------------------
module srr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  srr_pkg::cmd_t         head_cmd,
	output logic                  pop,
	output srr_pkg::back_status_t status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            ack_seq,
	output logic                  is_duplicate,
	output logic                  last
);
	import srr_pkg::*;

	localparam slot_idx_t LAST_SLOT = SLOT_W'(BUFFER_SLOTS-1);

	back_state_t state_q;
	back_state_t state_d;

	logic      slot_valid_q  [BUFFER_SLOTS];
	seq_t      slot_seq_q    [BUFFER_SLOTS];
	logic      slot_intact_q [BUFFER_SLOTS];

	seq_t      last_delivered_q;
	logic      any_delivered_q;
	seq_t      pend_seq_q;
	slot_idx_t scan_idx_q;

	logic      out_valid_q;
	seq_t      ack_seq_q;
	logic      dup_q;
	logic      last_q;

	logic      out_free;
	seq_t      scan_expected;
	logic      slot_hit;
	logic      slot_deliver;
	logic      scan_step;
	slot_idx_t store_idx;

	logic      out_load;
	seq_t      load_seq;
	logic      load_dup;
	logic      load_last;

	assign out_free      = !out_valid_q || !out_stall;
	assign scan_expected = next_seq(last_delivered_q);
	assign slot_hit      = slot_valid_q[scan_idx_q] && (slot_seq_q[scan_idx_q] == scan_expected);
	assign slot_deliver  = slot_hit && slot_intact_q[scan_idx_q];
	assign store_idx     = SLOT_MAP[head_cmd.seq];

	// The previous acknowledgement is held back until the next one is found,
	// so that the final one of an item can carry the last mark.
	assign scan_step = (state_q == ST_SCAN) && !(slot_deliver && !out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop && (head_cmd.kind == CMD_DELIVER)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_step && (scan_idx_q == LAST_SLOT)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		out_load  = 1'b0;
		load_seq  = pend_seq_q;
		load_dup  = 1'b0;
		load_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head_cmd.kind)
						CMD_DUP: begin
							if (out_free) begin
								pop       = 1'b1;
								out_load  = 1'b1;
								load_seq  = head_cmd.seq;
								load_dup  = 1'b1;
								load_last = 1'b1;
							end
						end
						CMD_STORE:   pop = 1'b1;
						CMD_DELIVER: pop = 1'b1;
						default:     pop = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				if (slot_deliver && out_free) begin
					out_load = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load  = 1'b1;
					load_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			last_delivered_q <= '0;
			any_delivered_q  <= 1'b0;
			scan_idx_q       <= '0;
			out_valid_q      <= 1'b0;
			for (int i = 0; i < BUFFER_SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if ((state_q == ST_IDLE) && pop) begin
				if (head_cmd.kind == CMD_DELIVER) begin
					last_delivered_q <= head_cmd.seq;
					any_delivered_q  <= 1'b1;
					scan_idx_q       <= '0;
				end else if (head_cmd.kind == CMD_STORE) begin
					slot_valid_q[store_idx] <= 1'b1;
				end
			end
			if (scan_step) begin
				if (slot_hit) begin
					slot_valid_q[scan_idx_q] <= 1'b0;
				end
				if (slot_deliver) begin
					last_delivered_q <= slot_seq_q[scan_idx_q];
				end
				if (scan_idx_q != LAST_SLOT) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && pop && (head_cmd.kind == CMD_STORE)) begin
			slot_seq_q[store_idx]    <= head_cmd.seq;
			slot_intact_q[store_idx] <= head_cmd.intact;
		end
		if ((state_q == ST_IDLE) && pop && (head_cmd.kind == CMD_DELIVER)) begin
			pend_seq_q <= head_cmd.seq;
		end else if (scan_step && slot_deliver) begin
			pend_seq_q <= slot_seq_q[scan_idx_q];
		end
		if (out_load) begin
			ack_seq_q <= load_seq;
			dup_q     <= load_dup;
			last_q    <= load_last;
		end
	end

	assign status.last_delivered = last_delivered_q;
	assign status.any_delivered  = any_delivered_q;
	assign status.idle           = (state_q == ST_IDLE);
	assign status.scanning       = (state_q == ST_SCAN);

	assign out_valid    = out_valid_q;
	assign ack_seq      = ack_seq_q;
	assign is_duplicate = dup_q;
	assign last         = last_q;

endmodule

>>> rtl/core/selective_repeat_receiver_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top
// Selective repeat receiver: acknowledges in-order packets, replays
// acknowledgements for old ones and parks early ones in reorder slots.
// ----------------------------------------------------------------------------
// Each item is one arriving packet (seq_num, intact). The block returns zero
// or more acknowledgement items, the final one of each packet marked by last.
// An intact packet with the next expected number is acknowledged, after which
// the 16 reorder slots are scanned once in ascending order from slot 0, one slot
// per clock unless a stalled output holds it, and each parked packet found in
// that pass that continues the sequence is acknowledged too; a corrupt parked
// packet found that way is discarded. Such a packet passes the queue, then the
// slot scan, then the loading of its final acknowledgement into the output
// register, which hands it off. A duplicate passes the queue into the output
// register, a parked packet passes the queue into its slot, and a corrupt
// in-order packet is dropped in its accept cycle. A new packet is taken only
// once the previous one has been carried out, because its classification
// depends on the last delivered number; a stalled output register holds up the
// scan only when it has another acknowledgement ready.
`include "assert_macros.svh"

module selective_repeat_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] seq_num,
	input  logic       intact,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] ack_seq,
	output logic       is_duplicate,
	output logic       last
);
	import srr_pkg::*;

	back_status_t  back_status;
	queue_status_t q_status;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	logic          head_valid;
	cmd_t          head_cmd;

	// Front end: accepts and classifies arriving packets.
	srr_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seq_num     (seq_num),
		.intact      (intact),
		.back_status (back_status),
		.q_status    (q_status),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// Decoupling queue between classification and execution.
	srr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.status     (q_status)
	);

	// Back end: reorder slots, slot scan and acknowledgement output.
	srr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.status       (back_status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ack_seq      (ack_seq),
		.is_duplicate (is_duplicate),
		.last         (last)
	);

	// A duplicate acknowledgement is always the only one of its packet.
	`SRR_ASSERT_IMP(a_dup_is_last, clk, arst_n, out_valid && is_duplicate, last)

	// The slot scan only runs after something has been delivered.
	`SRR_ASSERT_IMP(a_scan_after_delivery, clk, arst_n, back_status.scanning, back_status.any_delivered)

	// The front never lets a second command into the queue.
	`SRR_ASSERT_ALWAYS(a_queue_never_full, clk, arst_n, !q_status.full)

endmodule
